// ===== sv/tdsfc_pkg.sv =====
// Shared types and constants for the TDS sensor frame checker.
package tdsfc_pkg;

  localparam logic [7:0] PRE_TDS    = 8'hAA;
  localparam logic [7:0] PRE_TEMP   = 8'hAB;
  localparam logic [7:0] PRE_DEVERR = 8'hAC;

  localparam int HALF_LEN  = 6;
  localparam int REPLY_LEN = 12;

  localparam logic [2:0] K_PREAMBLE = 3'd0;
  localparam logic [2:0] K_CHECKSUM = 3'd5;
  localparam logic [3:0] POS_HALF   = 4'(HALF_LEN);
  localparam logic [3:0] POS_LAST   = 4'(REPLY_LEN - 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DEV_ERR = 2'd1,
    ST_BAD_PRE = 2'd2,
    ST_SUM_ERR = 2'd3
  } status_t;

  typedef struct packed {
    logic        half_index;
    status_t     status;
    logic [7:0]  preamble;
    logic [7:0]  error_code;
    logic [15:0] value_one;
    logic [15:0] value_two;
    logic        publish;
    logic        frame_end;
  } result_t;

endpackage

// ===== sv/tdsfc_if.sv =====
// Valid/ready channel interfaces for the input byte and the half result.
interface tdsfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
  modport mon (input valid, ready, rx_byte, frame_start);
endinterface

interface tdsfc_out_if;
  logic        valid;
  logic        ready;
  logic        half_index;
  logic [1:0]  status;
  logic [7:0]  preamble;
  logic [7:0]  error_code;
  logic [15:0] value_one;
  logic [15:0] value_two;
  logic        publish;
  logic        frame_end;

  modport source (output valid, half_index, status, preamble, error_code, value_one,
                  value_two, publish, frame_end, input ready);
  modport sink (input valid, half_index, status, preamble, error_code, value_one,
                value_two, publish, frame_end, output ready);
  modport mon (input valid, ready, half_index, status, preamble, error_code, value_one,
               value_two, publish, frame_end);
endinterface

// ===== sv/tdsfc_tracker.sv =====
// Byte position tracking, half assembly and per-half check.
module tdsfc_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  output logic             res_valid,
  output tdsfc_pkg::result_t res
);
  import tdsfc_pkg::*;

  logic [3:0] byte_position;
  logic [3:0] byte_position_next;
  logic [7:0] running_sum;
  logic [7:0] held_preamble;
  logic [7:0] held_bytes [4];
  logic       skip_rest;
  logic       skip_rest_next;

  logic [3:0] pos;
  logic       skip_cur;
  logic       half;
  logic [2:0] k;
  logic [1:0] slot;
  status_t    st;

  always_comb begin
    pos      = frame_start ? 4'd0 : byte_position;
    skip_cur = frame_start ? 1'b0 : skip_rest;
    if (pos > POS_LAST) begin
      pos = 4'd0;
    end
    half = (pos >= POS_HALF);
    k    = half ? 3'(pos - POS_HALF) : pos[2:0];
    slot = 2'(k - 3'd1);

    if (!half && held_preamble == PRE_DEVERR) begin
      st = ST_DEV_ERR;
    end else if (held_preamble != PRE_TDS && held_preamble != PRE_TEMP) begin
      st = ST_BAD_PRE;
    end else if (running_sum != rx_byte) begin
      st = ST_SUM_ERR;
    end else begin
      st = ST_OK;
    end

    res_valid      = (k == K_CHECKSUM) && !(half && skip_cur);
    res.half_index = half;
    res.status     = st;
    res.preamble   = held_preamble;
    res.error_code = held_bytes[0];
    res.value_one  = {held_bytes[0], held_bytes[1]};
    res.value_two  = {held_bytes[2], held_bytes[3]};
    res.publish    = (st == ST_OK) &&
                     ((!half && held_preamble == PRE_TDS) || (half && held_preamble == PRE_TEMP));
    res.frame_end  = half || (st != ST_OK);

    if (pos == POS_LAST) begin
      byte_position_next = 4'd0;
      skip_rest_next     = 1'b0;
    end else begin
      byte_position_next = pos + 4'd1;
      skip_rest_next     = (res_valid && !half && st != ST_OK) ? 1'b1 : skip_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      skip_rest     <= 1'b0;
      running_sum   <= '0;
      held_preamble <= '0;
      for (int i = 0; i < 4; i++) begin
        held_bytes[i] <= '0;
      end
    end else if (accept) begin
      byte_position <= byte_position_next;
      skip_rest     <= skip_rest_next;
      if (k == K_PREAMBLE) begin
        held_preamble <= rx_byte;
        running_sum   <= rx_byte;
      end else if (k < K_CHECKSUM) begin
        held_bytes[slot] <= rx_byte;
        running_sum      <= running_sum + rx_byte;
      end
    end
  end

endmodule

// ===== sv/tdsfc_out_reg.sv =====
// Result register between the check logic and the output channel.
module tdsfc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  tdsfc_pkg::result_t res,
  input  logic               out_ready,
  output logic               out_valid,
  output tdsfc_pkg::result_t out_res,
  output logic               free
);
  import tdsfc_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_res <= res;
    end
  end

endmodule

// ===== sv/tds_sensor_frame_checker_core.sv =====
// Top level of the TDS sensor frame checker.
// Usage:
//   in_ch carries one reply byte per item (rx_byte) with frame_start marking
//   byte 0 of a new 12-byte reply. out_ch carries one status item per checked
//   half: on byte 5 and on byte 11, except that a failed first half ends the
//   reply and its second half gives no item.
// Result: the result item is registered and valid in the cycle after byte 5 or 11 is accepted.
// Throughput: one byte per cycle when not stalled; the per-byte update is an
//   8-bit add and byte compares between tracking state and result register.
// Stall: in_ch.ready is low only while the result register holds an item that
//   out_ch does not take; a held result blocks further bytes until taken.
// Reset: rst clears the byte position, the checksum, the held bytes, the skip
//   flag and the result valid; the next byte is taken as byte 0 of a reply.
module tds_sensor_frame_checker_core (
  input logic       clk,
  input logic       rst,
  tdsfc_in_if.sink  in_ch,
  tdsfc_out_if.source out_ch
);
  import tdsfc_pkg::*;

  logic    accept;
  logic    res_valid;
  logic    free;
  result_t res;
  result_t out_res;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = free;

  tdsfc_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .rx_byte     (in_ch.rx_byte),
    .frame_start (in_ch.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  tdsfc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .res       (res),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .free      (free)
  );

  assign out_ch.half_index = out_res.half_index;
  assign out_ch.status     = out_res.status;
  assign out_ch.preamble   = out_res.preamble;
  assign out_ch.error_code = out_res.error_code;
  assign out_ch.value_one  = out_res.value_one;
  assign out_ch.value_two  = out_res.value_two;
  assign out_ch.publish    = out_res.publish;
  assign out_ch.frame_end  = out_res.frame_end;

endmodule

// ===== sv/tdsfc_checker.sv =====
// Port-level assertions for the TDS sensor frame checker and their bind.
module tdsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_half_index,
  input logic [1:0]  out_status,
  input logic [7:0]  out_preamble,
  input logic [15:0] out_value_one,
  input logic [15:0] out_value_two,
  input logic        out_publish,
  input logic        out_frame_end
);
  import tdsfc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_value_one) && $stable(out_value_two))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  a_fail_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_half_index || out_status != ST_OK) |-> out_frame_end)
    else $error("failed or second half without frame end");

  a_publish: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_publish |-> out_status == ST_OK
      && (out_preamble == PRE_TDS || out_preamble == PRE_TEMP))
    else $error("publish on a bad half");

endmodule

bind tds_sensor_frame_checker_core tdsfc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_half_index (out_ch.half_index),
  .out_status     (out_ch.status),
  .out_preamble   (out_ch.preamble),
  .out_value_one  (out_ch.value_one),
  .out_value_two  (out_ch.value_two),
  .out_publish    (out_ch.publish),
  .out_frame_end  (out_ch.frame_end)
);

// ===== verif/tb_tds_sensor_frame_checker_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the TDS sensor frame checker: byte driver, result monitor.
module tb_tds_sensor_frame_checker_core;
  import tdsfc_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_BYTES = 1800;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } reply_byte_t;

  logic clk;
  logic rst;

  tdsfc_in_if  in_ch ();
  tdsfc_out_if out_ch ();

  tds_sensor_frame_checker_core uut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  reply_byte_t pending_bytes[$];
  result_t     expected_halves[$];

  logic [3:0] reply_pos;
  logic [7:0] half_sum;
  logic [7:0] half_preamble;
  logic [7:0] half_data[4];
  logic       skip_second;

  bit          in_taken;
  bit          out_taken;
  bit          byte_burst;
  bit          result_burst;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned bytes_taken;
  int unsigned halves_checked;
  int unsigned status_count[4];
  reply_byte_t next_byte;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function void track_reply_byte(logic [7:0] b, logic start);
    logic [3:0] pos;
    logic       second;
    logic [2:0] k;
    status_t    st;
    result_t    r;
    if (start) begin
      reply_pos   = '0;
      skip_second = 1'b0;
    end
    pos = (reply_pos > POS_LAST) ? 4'd0 : reply_pos;
    second = (pos >= POS_HALF);
    k = 3'(second ? pos - POS_HALF : pos);
    if (k == K_PREAMBLE) begin
      half_preamble = b;
      half_sum      = b;
    end else if (k < K_CHECKSUM) begin
      half_data[2'(k - 3'd1)] = b;
      half_sum = half_sum + b;
    end else if (!(second && skip_second)) begin
      if (!second && half_preamble == PRE_DEVERR) st = ST_DEV_ERR;
      else if (half_preamble != PRE_TDS && half_preamble != PRE_TEMP) st = ST_BAD_PRE;
      else if (half_sum != b) st = ST_SUM_ERR;
      else st = ST_OK;
      r.half_index = second;
      r.status     = st;
      r.preamble   = half_preamble;
      r.error_code = half_data[0];
      r.value_one  = {half_data[0], half_data[1]};
      r.value_two  = {half_data[2], half_data[3]};
      r.publish    = (st == ST_OK) &&
                     (second ? half_preamble == PRE_TEMP : half_preamble == PRE_TDS);
      r.frame_end  = second || (st != ST_OK);
      if (!second && st != ST_OK) skip_second = 1'b1;
      expected_halves.push_back(r);
    end
    if (pos == POS_LAST) begin
      reply_pos   = '0;
      skip_second = 1'b0;
    end else begin
      reply_pos = pos + 4'd1;
    end
  endfunction

  function void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function void check_half();
    result_t want;
    if (expected_halves.size() == 0) begin
      $error("result item with nothing expected: half %0d status %0d",
             out_ch.half_index, out_ch.status);
      mismatches++;
      return;
    end
    want = expected_halves.pop_front();
    check_field("half_index", want.half_index, out_ch.half_index);
    check_field("status", want.status, out_ch.status);
    check_field("preamble", want.preamble, out_ch.preamble);
    check_field("error_code", want.error_code, out_ch.error_code);
    check_field("value_one", want.value_one, out_ch.value_one);
    check_field("value_two", want.value_two, out_ch.value_two);
    check_field("publish", want.publish, out_ch.publish);
    check_field("frame_end", want.frame_end, out_ch.frame_end);
    halves_checked++;
    status_count[want.status]++;
  endfunction

  function logic [7:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function logic [7:0] pick_preamble(bit second);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < (second ? 4 : 8)) return PRE_TDS;
    if (r < 12) return PRE_TEMP;
    if (r < 16) return PRE_DEVERR;
    return 8'($urandom);
  endfunction

  task automatic queue_reply(logic [7:0] pre0, logic [7:0] pre1, bit good0, bit good1,
                             bit start, int len);
    logic [7:0] bytes[12];
    logic [7:0] sum;
    for (int h = 0; h < 2; h++) begin
      bytes[h * 6] = h ? pre1 : pre0;
      sum = bytes[h * 6];
      for (int i = 1; i < 5; i++) begin
        bytes[h * 6 + i] = pick_data();
        sum = sum + bytes[h * 6 + i];
      end
      if (h ? good1 : good0) bytes[h * 6 + 5] = sum;
      else bytes[h * 6 + 5] = sum + 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < len; i++)
      pending_bytes.push_back('{rx_byte: bytes[i], frame_start: (i == 0) && start});
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (pending_bytes.size() > 0) begin
        next_byte = pending_bytes.pop_front();
        in_ch.rx_byte     <= next_byte.rx_byte;
        in_ch.frame_start <= next_byte.frame_start;
        in_ch.valid       <= 1'b1;
        if ($urandom_range(0, 49) == 0) byte_burst = !byte_burst;
        gap_left = byte_burst ? 0 : $urandom_range(0, 8);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 19) == 0) result_burst = !result_burst;
        stall_left = result_burst ? 0 : $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        check_half();
      end
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        bytes_taken++;
        track_reply_byte(in_ch.rx_byte, in_ch.frame_start);
      end
      if (in_taken || out_taken) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
          $display("tb_tds_sensor_frame_checker_core failed");
          $finish;
        end
      end
    end
  end

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    in_ch.valid       = 1'b0;
    in_ch.rx_byte     = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    reply_pos         = '0;
    half_sum          = '0;
    half_preamble     = '0;
    half_data         = '{default: '0};
    skip_second       = 1'b0;
    gap_left          = 0;
    stall_left        = 0;
    quiet_cycles      = 0;
    mismatches        = 0;

    queue_reply(PRE_TDS, PRE_DEVERR, 1'b1, 1'b1, 1'b1, 12);
    queue_reply(PRE_DEVERR, PRE_TDS, 1'b1, 1'b1, 1'b1, 7);
    queue_reply(PRE_TEMP, PRE_TEMP, 1'b0, 1'b1, 1'b1, 6);

    while (pending_bytes.size() < RANDOM_BYTES) begin
      case ($urandom_range(0, 19))
        0, 1: queue_reply(pick_preamble(1'b0), pick_preamble(1'b1),
                          $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                          1'b1, $urandom_range(1, 11));
        2: begin
          repeat ($urandom_range(1, 6))
            pending_bytes.push_back('{rx_byte: 8'($urandom),
                                      frame_start: $urandom_range(0, 3) == 0});
        end
        default: queue_reply(pick_preamble(1'b0), pick_preamble(1'b1),
                             $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
                             $urandom_range(0, 3) != 0, 12);
      endcase
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_bytes.size() == 0 && !in_ch.valid);
    wait (expected_halves.size() == 0);
    repeat (10) @(posedge clk);

    $display("Sent %0d reply bytes and checked %0d half results.", bytes_taken, halves_checked);
    $display("Statuses seen: ok %0d, device error %0d, bad preamble %0d, checksum %0d.",
             status_count[ST_OK], status_count[ST_DEV_ERR], status_count[ST_BAD_PRE],
             status_count[ST_SUM_ERR]);
    if (mismatches == 0 && expected_halves.size() == 0) begin
      $display("tb_tds_sensor_frame_checker_core passed");
    end else begin
      $display("tb_tds_sensor_frame_checker_core failed");
    end
    $finish;
  end

endmodule
